>>> rtl/core/fki_pkg.sv
// ----------------------------------------------------------------------------
// FASTA k-mer index stream: shared types and constants
// Transaction payloads, configuration fields, event kinds and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package fki_pkg;

   // Event kinds carried in rsp_type.event_kind
   localparam logic [2:0] EV_START  = 3'd0;
   localparam logic [2:0] EV_SYMBOL = 3'd1;
   localparam logic [2:0] EV_KMER   = 3'd2;
   localparam logic [2:0] EV_FINISH = 3'd3;
   localparam logic [2:0] EV_ERROR  = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] CSR_LETTER_ZERO  = 3'd0;
   localparam logic [2:0] CSR_LETTER_ONE   = 3'd1;
   localparam logic [2:0] CSR_LETTER_TWO   = 3'd2;
   localparam logic [2:0] CSR_LETTER_THREE = 3'd3;
   localparam logic [2:0] CSR_BOTH_CASES   = 3'd4;

   // Output queue depth; two entries must stay free to take any input
   localparam int          QDEPTH   = 4;
   localparam int          QIDX_W   = $clog2(QDEPTH);
   localparam int          QCNT_W   = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [31:0] sequence_number;
      logic [31:0] symbol_position;
      logic [23:0] kmer_index;
      logic [1:0]  symbol_code;
      logic [31:0] text_offset;
      logic        last_of_step;
   } rsp_type;

   typedef struct packed {
      logic [7:0] letter_zero;
      logic [7:0] letter_one;
      logic [7:0] letter_two;
      logic [7:0] letter_three;
      logic       accept_both_cases;
   } cfg_type;

   // Results produced by one input transaction (count is 0, 1 or 2)
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

`default_nettype wire

>>> rtl/core/fki_parse.sv
// ----------------------------------------------------------------------------
// FASTA k-mer index stream: parser
// Holds the parse state and turns one text byte into up to two events.
// ----------------------------------------------------------------------------
`default_nettype none

module fki_parse
   import fki_pkg::*;
#(
   parameter int DEPTH = 12
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     fire,
   input  wire req_type  req,
   input  wire cfg_type  cfg,
   output      push_type push
);

   localparam int         KW      = (2 * DEPTH > 24) ? 24 : 2 * DEPTH;
   localparam logic [3:0] RUN_MAX = 4'(DEPTH - 1);

   localparam logic [1:0] PH_SEEK   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_SEQ    = 2'd2;

   localparam logic [7:0] CH_GT  = 8'h3e;
   localparam logic [7:0] CH_NL  = 8'h0a;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   function automatic logic [7:0] up_case(input logic [7:0] c);
      return (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] low_case(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   endfunction

   function automatic logic char_match(input logic [7:0] b, input logic [7:0] letter,
                                       input logic both);
      if (both) begin
         return (b == up_case(letter)) || (b == low_case(letter));
      end
      return b == letter;
   endfunction

   logic [1:0]    phase_ff, phase_in;
   logic [KW-1:0] kmer_ff, kmer_in;
   logic [3:0]    run_ff, run_in;
   logic [31:0]   seq_ff, seq_in;
   logic [31:0]   pos_ff, pos_in;
   logic [31:0]   bytes_ff, bytes_in;

   logic          hit;
   logic [1:0]    code;
   logic [KW-1:0] kmer_shifted;
   logic [7:0]    b;
   rsp_type       blank;

   assign b = req.text_byte;
   assign kmer_shifted = {kmer_ff[KW-3:0], code};

   // highest symbol number wins when letters overlap
   always_comb begin
      hit  = 1'b1;
      code = 2'd0;
      priority if (char_match(b, cfg.letter_three, cfg.accept_both_cases)) begin
         code = 2'd3;
      end else if (char_match(b, cfg.letter_two, cfg.accept_both_cases)) begin
         code = 2'd2;
      end else if (char_match(b, cfg.letter_one, cfg.accept_both_cases)) begin
         code = 2'd1;
      end else if (char_match(b, cfg.letter_zero, cfg.accept_both_cases)) begin
         code = 2'd0;
      end else begin
         hit = 1'b0;
      end
   end

   always_comb begin
      blank                 = '0;
      blank.sequence_number = seq_ff;

      phase_in = phase_ff;
      kmer_in  = kmer_ff;
      run_in   = run_ff;
      seq_in   = seq_ff;
      pos_in   = pos_ff;
      bytes_in = bytes_ff;

      push        = '0;
      push.first  = blank;
      push.second = blank;

      if (req.end_of_input) begin
         push.count            = 2'd1;
         push.first.event_kind = (phase_ff == PH_SEQ) ? EV_FINISH : EV_ERROR;
         phase_in = PH_SEEK;
         kmer_in  = '0;
         run_in   = '0;
         seq_in   = 32'd1;
         pos_in   = '0;
         bytes_in = '0;
      end else begin
         bytes_in = bytes_ff + 32'd1;
         unique case (phase_ff)
            PH_HEADER: begin
               if (b == CH_NL) begin
                  push.count             = 2'd1;
                  push.first.event_kind  = EV_START;
                  push.first.text_offset = bytes_in;
                  phase_in = PH_SEQ;
                  pos_in   = '0;
                  kmer_in  = '0;
                  run_in   = '0;
               end
            end
            PH_SEQ: begin
               if (b == CH_GT) begin
                  push.count            = 2'd1;
                  push.first.event_kind = EV_FINISH;
                  seq_in   = seq_ff + 32'd1;
                  phase_in = PH_HEADER;
                  kmer_in  = '0;
                  run_in   = '0;
               end else if (b == CH_SP || b == CH_TAB || b == CH_NL) begin
                  // skip whitespace
               end else begin
                  pos_in = pos_ff + 32'd1;
                  if (hit) begin
                     push.count                 = 2'd1;
                     push.first.event_kind      = EV_SYMBOL;
                     push.first.symbol_position = pos_ff;
                     push.first.symbol_code     = code;
                     kmer_in = kmer_shifted;
                     if (run_ff >= RUN_MAX) begin
                        run_in                      = RUN_MAX;
                        push.count                  = 2'd2;
                        push.second.event_kind      = EV_KMER;
                        push.second.symbol_position = pos_ff;
                        push.second.symbol_code     = code;
                        push.second.kmer_index      = 24'(kmer_shifted);
                     end else begin
                        run_in = run_ff + 4'd1;
                     end
                  end else begin
                     kmer_in = '0;
                     run_in  = '0;
                  end
               end
            end
            default: begin
               // seeking the first header; an unused code behaves the same
               phase_in = (b == CH_GT) ? PH_HEADER : PH_SEEK;
            end
         endcase
      end

      push.first.last_of_step  = (push.count == 2'd1);
      push.second.last_of_step = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         kmer_ff  <= '0;
         run_ff   <= '0;
         seq_ff   <= 32'd1;
         pos_ff   <= '0;
         bytes_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         kmer_ff  <= kmer_in;
         run_ff   <= run_in;
         seq_ff   <= seq_in;
         pos_ff   <= pos_in;
         bytes_ff <= bytes_in;
      end
   end

   a_pair_is_symbol_then_kmer: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |->
         push.first.event_kind == EV_SYMBOL && push.second.event_kind == EV_KMER)
      else $error("two results must be a symbol followed by a k-mer");

   a_run_saturates: assert property (@(posedge clock) disable iff (reset)
      run_ff <= RUN_MAX)
      else $error("valid run exceeded its limit");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && req.end_of_input |=> phase_ff == PH_SEEK && seq_ff == 32'd1)
      else $error("end of input did not restart parsing");

endmodule

`default_nettype wire

>>> rtl/core/fki_outq.sv
// ----------------------------------------------------------------------------
// FASTA k-mer index stream: result queue
// Takes up to two results a cycle, hands out one a cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module fki_outq
   import fki_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output      logic     room,
   output      logic     rsp_valid,
   input  wire logic     rsp_stall,
   output      rsp_type  rsp_payload
);

   rsp_type             slot_ff [QDEPTH];
   logic [QIDX_W-1:0]   head_ff, head_in;
   logic [QIDX_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = slot_ff[head_ff];
   assign pop         = rsp_valid && !rsp_stall;
   // keep two slots free so any transaction fits
   assign room        = (count_ff <= QCNT_W'(QDEPTH - 2));

   always_comb begin
      head_in  = head_ff + QIDX_W'(pop);
      tail_in  = tail_ff + QIDX_W'(push.count);
      count_in = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[tail_ff + QIDX_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("result pushed without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count out of range");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (tail_ff - head_ff) == count_ff[QIDX_W-1:0])
      else $error("queue count disagrees with pointers");

endmodule

`default_nettype wire

>>> rtl/core/fasta_kmer_index_stream.sv
// ----------------------------------------------------------------------------
// FASTA k-mer index stream
// Parses FASTA text a byte at a time and reports sequence starts, symbols,
// k-mer indexes and sequence ends.
// ----------------------------------------------------------------------------
// The block takes one text byte per req transaction and produces zero, one or
// two rsp transactions for it: a start event when a header line ends, a symbol
// event for every sequence byte that matches one of the four configured
// letters, a k-mer event once DEPTH matching symbols have been seen in a row, a
// finish event on '>' or end of input inside sequence text, and an error event
// when input ends while seeking the first header or inside a header line. A
// byte is parsed in the cycle it is accepted and its results are registered in
// a four-entry result queue. Throughput is one byte per cycle while bytes cause
// at most one result each and rsp_stall stays low; the rsp side drains one
// result per cycle while rsp_stall is low. A byte that yields a symbol and a
// k-mer takes two rsp transactions, and req_stall rises whenever fewer than two
// queue slots are free. The user must write letters and case folding through
// the csr port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module fasta_kmer_index_stream
   import fki_pkg::*;
#(
   parameter int DEPTH = 12
) (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire req_type    req_payload,

   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      rsp_type    rsp_payload,

   input  wire logic       csr_write_enable,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_data
);

   cfg_type  cfg_ff;
   push_type push;
   push_type push_raw;
   logic     room;
   logic     fire;

   // Accept a transaction only while the queue can absorb two results
   assign req_stall = !room;
   assign fire      = req_valid && room;

   // Configuration registers; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.letter_zero       <= 8'd65;
         cfg_ff.letter_one        <= 8'd67;
         cfg_ff.letter_two        <= 8'd71;
         cfg_ff.letter_three      <= 8'd84;
         cfg_ff.accept_both_cases <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LETTER_ZERO:  cfg_ff.letter_zero       <= csr_data;
            CSR_LETTER_ONE:   cfg_ff.letter_one        <= csr_data;
            CSR_LETTER_TWO:   cfg_ff.letter_two        <= csr_data;
            CSR_LETTER_THREE: cfg_ff.letter_three      <= csr_data;
            CSR_BOTH_CASES:   cfg_ff.accept_both_cases <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Parse state and event generation; results gated by the accept strobe
   fki_parse #(
      .DEPTH (DEPTH)
   ) u_parse (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_payload),
      .cfg   (cfg_ff),
      .push  (push_raw)
   );

   always_comb begin
      push = push_raw;
      if (!fire) begin
         push.count = 2'd0;
      end
   end

   // Result queue doubles as the output register
   fki_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_start_has_offset: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 && push.first.event_kind == EV_START |->
         push.first.text_offset != 32'd0 || $past(fire))
      else $error("start event without a text offset");

   a_idle_no_push: assert property (@(posedge clock) disable iff (reset)
      !fire |-> push.count == 2'd0)
      else $error("results pushed without an accepted transaction");

   a_end_single_result: assert property (@(posedge clock) disable iff (reset)
      fire && req_payload.end_of_input |->
         push.count == 2'd1 &&
         (push.first.event_kind == EV_FINISH || push.first.event_kind == EV_ERROR))
      else $error("end of input must give exactly one finish or error event");

endmodule

`default_nettype wire

>>> test/fasta_kmer_index_stream_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FASTA k-mer index stream testbench
// Feeds directed and random FASTA text through the req channel, predicts the
// start, symbol, k-mer, finish and error events of every byte, and checks each
// rsp transaction field by field in order, under random gaps and back pressure.
// ----------------------------------------------------------------------------

module fasta_kmer_index_stream_tb;
   import fki_pkg::*;

   localparam int          KMER_DEPTH   = 12;
   localparam logic [23:0] KMER_MASK    = (2 * KMER_DEPTH >= 24) ? 24'hFFFFFF :
                                          24'((64'd1 << (2 * KMER_DEPTH)) - 1);
   localparam logic [7:0]  CH_GT        = 8'h3E;
   localparam logic [7:0]  CH_LF        = 8'h0A;
   localparam logic [7:0]  CH_SP        = 8'h20;
   localparam logic [7:0]  CH_TAB       = 8'h09;
   localparam logic [7:0]  CH_CR        = 8'h0D;
   localparam logic [2:0]  NO_SYMBOL    = 3'd4;
   // results are registered in the queue at acceptance; the drain wait covers any slack
   localparam int          DRAIN_CYCLES = 8;
   localparam int          CYCLE_LIMIT  = 400000;

   typedef enum logic [1:0] {PHASE_SEEK, PHASE_HEADER, PHASE_SEQ} parse_phase_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   req_type     req_payload      = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index        = CSR_LETTER_ZERO;
   logic [7:0]  csr_data         = 8'h00;

   // Parser copy kept alongside the block: letters, phase, rolling k-mer, counters
   cfg_type         ps_cfg = '{8'h41, 8'h43, 8'h47, 8'h54, 1'b1};
   parse_phase_type ps_phase;
   logic [23:0]     ps_kmer;
   int              ps_run;
   logic [31:0]     ps_seq;
   logic [31:0]     ps_pos;
   logic [31:0]     ps_bytes;

   rsp_type expected_events[$];

   int mismatch_count    = 0;
   int events_checked    = 0;
   int kmers_predicted   = 0;
   int working_items     = 0;
   int settings_tried    = 0;
   int cycle_count       = 0;
   int stall_left        = 0;
   int hold_off_request  = 0;
   bit sender_pacing     = 1'b1;
   bit rsp_pacing        = 1'b1;

   always #10 clock = ~clock;

   fasta_kmer_index_stream #(.DEPTH(KMER_DEPTH)) dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_payload,
      .rsp_valid,
      .rsp_stall,
      .rsp_payload,
      .csr_write_enable,
      .csr_index,
      .csr_data
   );

   // ------------------------------------------------------------------------
   // Parser prediction
   // ------------------------------------------------------------------------

   function automatic void reset_parser();
      ps_phase = PHASE_SEEK;
      ps_kmer  = '0;
      ps_run   = 0;
      ps_seq   = 32'd1;
      ps_pos   = '0;
      ps_bytes = '0;
   endfunction

   function automatic logic [7:0] upper_of(input logic [7:0] c);
      return (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] lower_of(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   endfunction

   function automatic bit letter_hit(input logic [7:0] b, input logic [7:0] letter);
      if (ps_cfg.accept_both_cases)
         return b == upper_of(letter) || b == lower_of(letter);
      return b == letter;
   endfunction

   // Overlapping letters: the highest symbol number wins, so test from three down.
   function automatic logic [2:0] symbol_of(input logic [7:0] b);
      if (letter_hit(b, ps_cfg.letter_three)) return 3'd3;
      if (letter_hit(b, ps_cfg.letter_two))   return 3'd2;
      if (letter_hit(b, ps_cfg.letter_one))   return 3'd1;
      if (letter_hit(b, ps_cfg.letter_zero))  return 3'd0;
      return NO_SYMBOL;
   endfunction

   function automatic rsp_type make_event(input logic [2:0] kind, input logic [31:0] pos,
                                          input logic [23:0] kmer, input logic [1:0] code,
                                          input logic [31:0] offset);
      rsp_type ev;
      ev.event_kind      = kind;
      ev.sequence_number = ps_seq;
      ev.symbol_position = pos;
      ev.kmer_index      = kmer;
      ev.symbol_code     = code;
      ev.text_offset     = offset;
      ev.last_of_step    = 1'b0;
      return ev;
   endfunction

   // Advance the parser by one accepted transaction and queue the events it causes.
   function automatic void predict_step(input req_type item);
      rsp_type    produced[$];
      logic [2:0] code;
      logic [7:0] b;
      b = item.text_byte;
      if (item.end_of_input) begin
         // end in sequence text finishes it; anywhere else it is an error
         produced.push_back(make_event(ps_phase == PHASE_SEQ ? EV_FINISH : EV_ERROR,
                                       '0, '0, '0, '0));
         reset_parser();
         working_items++;
      end else begin
         ps_bytes++;
         case (ps_phase)
            PHASE_SEEK: if (b == CH_GT) ps_phase = PHASE_HEADER;
            PHASE_HEADER: if (b == CH_LF) begin
               produced.push_back(make_event(EV_START, '0, '0, '0, ps_bytes));
               ps_phase = PHASE_SEQ;
               ps_pos   = '0;
               ps_kmer  = '0;
               ps_run   = 0;
               working_items++;
            end
            default: begin
               if (b == CH_GT) begin
                  produced.push_back(make_event(EV_FINISH, '0, '0, '0, '0));
                  ps_seq++;
                  ps_phase = PHASE_HEADER;
                  ps_kmer  = '0;
                  ps_run   = 0;
                  working_items++;
               end else if (b != CH_SP && b != CH_TAB && b != CH_LF) begin
                  working_items++;
                  code = symbol_of(b);
                  if (code != NO_SYMBOL) begin
                     produced.push_back(make_event(EV_SYMBOL, ps_pos, '0, code[1:0], '0));
                     ps_kmer = ((ps_kmer << 2) | 24'(code[1:0])) & KMER_MASK;
                     // run saturates one short of the depth; every further hit emits
                     if (ps_run >= KMER_DEPTH - 1) begin
                        ps_run = KMER_DEPTH - 1;
                        produced.push_back(make_event(EV_KMER, ps_pos, ps_kmer,
                                                      code[1:0], '0));
                        kmers_predicted++;
                     end else begin
                        ps_run++;
                     end
                  end else begin
                     ps_kmer = '0;
                     ps_run  = 0;
                  end
                  ps_pos++;
               end
            end
         endcase
      end
      if (produced.size() > 0)
         produced[produced.size() - 1].last_of_step = 1'b1;
      foreach (produced[i])
         expected_events.push_back(produced[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] header_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == CH_LF) ? 8'h2A : b;
   endfunction

   // Pick one of the current letters, sometimes with its case flipped.
   function automatic logic [7:0] any_letter();
      logic [7:0] l;
      case ($urandom_range(0, 3))
         0: l = ps_cfg.letter_zero;
         1: l = ps_cfg.letter_one;
         2: l = ps_cfg.letter_two;
         default: l = ps_cfg.letter_three;
      endcase
      if ($urandom_range(0, 3) == 0)
         l = $urandom_range(0, 1) ? lower_of(l) : upper_of(l);
      return l;
   endfunction

   function automatic logic [7:0] sequence_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 78) return any_letter();
      if (pick < 88) begin
         case ($urandom_range(0, 2))
            0: return CH_SP;
            1: return CH_TAB;
            default: return CH_LF;
         endcase
      end
      if (pick < 97) return 8'($urandom_range(0, 255));
      return CH_CR;
   endfunction

   // Offer one transaction, hold it until accepted, then maybe drop valid for a gap.
   task automatic send_req(input logic [7:0] text, input logic ends);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= '{text_byte: text, end_of_input: ends};
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_step(req_payload);
      if (sender_pacing && $urandom_range(0, 99) < 30) begin
         gap = gap_length();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      foreach (s[i])
         send_req(s[i], 1'b0);
   endtask

   // Drop valid and wait for every expected event, then let the pipe go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_LETTER_ZERO:  ps_cfg.letter_zero       = data;
         CSR_LETTER_ONE:   ps_cfg.letter_one        = data;
         CSR_LETTER_TWO:   ps_cfg.letter_two        = data;
         CSR_LETTER_THREE: ps_cfg.letter_three      = data;
         CSR_BOTH_CASES:   ps_cfg.accept_both_cases = data[0];
         default: ;
      endcase
   endtask

   task automatic apply_letters(input logic [7:0] l0, input logic [7:0] l1,
                                input logic [7:0] l2, input logic [7:0] l3,
                                input logic both);
      settle();
      write_csr(CSR_LETTER_ZERO, l0);
      write_csr(CSR_LETTER_ONE, l1);
      write_csr(CSR_LETTER_TWO, l2);
      write_csr(CSR_LETTER_THREE, l3);
      // upper bits are don't-care for the one-bit register; toggle them anyway
      write_csr(CSR_BOTH_CASES, {7'($urandom_range(0, 127)), both});
      settings_tried++;
   endtask

   // One header line and a body of random sequence text.
   task automatic send_record(input int body_len);
      send_req(CH_GT, 1'b0);
      repeat ($urandom_range(0, 6)) send_req(header_byte(), 1'b0);
      send_req(CH_LF, 1'b0);
      repeat (body_len) send_req(sequence_byte(), 1'b0);
   endtask

   // Mostly well-formed records; some stray ends, noise and cut-off headers.
   task automatic run_stream(input int budget);
      int stop_at;
      int pick;
      stop_at = working_items + budget;
      while (working_items < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            send_record(($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                    : $urandom_range(1, 30));
         end else if (pick < 88) begin
            send_req(8'($urandom_range(0, 255)), 1'b1);
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 4)) send_req(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            send_req(CH_GT, 1'b0);
            repeat ($urandom_range(0, 3)) send_req(header_byte(), 1'b0);
            send_req(8'($urandom_range(0, 255)), 1'b1);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset letters: skip before the first header, header start offset, mixed case
   // symbols, ignored whitespace, invalid bytes (CR and 0xFF included), finish on
   // '>', finish on end in text, error on end while seeking and inside a header.
   task automatic test_directed_events();
      send_req(8'h00, 1'b0);
      send_text(">h\nAcGt \t\nN");
      send_req(CH_CR, 1'b0);
      send_req(8'hFF, 1'b0);
      send_text(">\nT");
      send_req(8'h00, 1'b1);
      send_req(8'h00, 1'b1);
      send_text(">q");
      send_req(8'hFF, 1'b1);
      settle();
   endtask

   // Stall rsp for a long stretch while bytes keep coming back to back, so the
   // result queue fills and req_stall rises; the run is long enough for k-mers.
   task automatic test_backpressure();
      sender_pacing = 1'b0;
      rsp_pacing    = 1'b0;
      send_text(">p\n");
      hold_off_request = 300;
      repeat (48) send_req(any_letter(), 1'b0);
      send_req(8'h00, 1'b1);
      settle();
      sender_pacing = 1'b1;
      rsp_pacing    = 1'b1;
   endtask

   // Walk through several letter settings, extremes and overlaps among them.
   task automatic test_letter_settings();
      apply_letters("A", "C", "G", "T", 1'b0);
      run_stream(65);
      apply_letters("a", "c", "g", "t", 1'b1);
      run_stream(65);
      apply_letters(8'h00, 8'hFF, 8'h80, 8'h7F, 1'b1);
      run_stream(65);
      // A matches letters zero and one, G and g letters two and three
      apply_letters("A", "a", "G", "g", 1'b1);
      run_stream(65);
      // a stretch with no idling on either side
      sender_pacing = 1'b0;
      rsp_pacing    = 1'b0;
      apply_letters(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      run_stream(65);
      sender_pacing = 1'b1;
      rsp_pacing    = 1'b1;
      apply_letters("A", "C", "G", "T", 1'b1);
      run_stream(65);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off counted here on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (hold_off_request > 0) begin
         rsp_stall <= 1'b1;
         stall_left       = hold_off_request - 1;
         hold_off_request = 0;
      end else if (rsp_pacing && $urandom_range(0, 99) < 25) begin
         rsp_stall <= 1'b1;
         stall_left = gap_length() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Result checking: every accepted rsp transaction against the oldest event
   // ------------------------------------------------------------------------
   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_events.size() == 0) begin
            $error("event_kind: expected no result, got %0h", rsp_payload.event_kind);
            mismatch_count++;
         end else begin
            want = expected_events.pop_front();
            compare_field("event_kind", want.event_kind, rsp_payload.event_kind);
            compare_field("sequence_number", want.sequence_number,
                          rsp_payload.sequence_number);
            compare_field("symbol_position", want.symbol_position,
                          rsp_payload.symbol_position);
            compare_field("kmer_index", want.kmer_index, rsp_payload.kmer_index);
            compare_field("symbol_code", want.symbol_code, rsp_payload.symbol_code);
            compare_field("text_offset", want.text_offset, rsp_payload.text_offset);
            compare_field("last_of_step", want.last_of_step, rsp_payload.last_of_step);
            events_checked++;
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of tests
   // ------------------------------------------------------------------------
   initial begin : run_tests
      int waited;
      reset_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_events();
      test_backpressure();
      test_letter_settings();

      // Wait out the last events with a bound, then let the block go quiet.
      req_valid <= 1'b0;
      waited = 0;
      while (expected_events.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_events.size() != 0) begin
         $error("%0d expected events never arrived", expected_events.size());
         mismatch_count++;
      end

      $display("Run covered %0d parsed text transactions over %0d letter settings,",
               working_items, settings_tried + 1);
      $display("checking %0d events, %0d of them k-mer indexes, with one long rsp hold-off.",
               events_checked, kmers_predicted);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
